// File: sv/ptld_pkg.sv
// ----------------------------------------------------------------------------
// ptld_pkg
// Shared types and constants for the proximity toggle lamp dimmer.
// ----------------------------------------------------------------------------
package ptld_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegNearThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWindowStart    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowEnd      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLevelInWindow  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelOutside   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSampleInterval = 3'd5;

  localparam logic [15:0] SampleIntervalReset = 16'd1000;
  localparam logic [15:0] TickSat             = 16'hFFFF;
  localparam logic [7:0]  RampUpStep          = 8'd1;
  localparam logic [7:0]  RampDownStep        = 8'd10;
  localparam logic [7:0]  LevelFull           = 8'd255;

  typedef struct packed {
    logic [9:0]  near_threshold;
    logic [4:0]  window_start_hour;
    logic [4:0]  window_end_hour;
    logic [7:0]  level_in_window;
    logic [7:0]  level_outside;
    logic [15:0] sample_interval;
  } ptld_cfg_t;

  typedef struct packed {
    logic [7:0] lamp_level;
    logic [7:0] indicator_level;
    logic       switch_on;
    logic [1:0] gesture_count;
    logic       in_window;
  } ptld_result_t;

endpackage

// File: sv/ptld_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptld_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ptld_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptld_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ptld_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ptld_pkg::ptld_cfg_t           cfg_o
);
  import ptld_pkg::*;

  ptld_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                   <= '0;
      cfg_q.sample_interval   <= SampleIntervalReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegNearThreshold:  cfg_q.near_threshold    <= cfg_wdata_i[9:0];
        RegWindowStart:    cfg_q.window_start_hour <= cfg_wdata_i[4:0];
        RegWindowEnd:      cfg_q.window_end_hour   <= cfg_wdata_i[4:0];
        RegLevelInWindow:  cfg_q.level_in_window   <= cfg_wdata_i[7:0];
        RegLevelOutside:   cfg_q.level_outside     <= cfg_wdata_i[7:0];
        RegSampleInterval: cfg_q.sample_interval   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/ptld_step.sv
// ----------------------------------------------------------------------------
// ptld_step
// Per-tick state update: sampling, gesture counting, window and level ramp.
// ----------------------------------------------------------------------------
module ptld_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [4:0]             hour_now_i,
  input  logic [9:0]             range_cm_i,
  input  ptld_pkg::ptld_cfg_t    cfg_i,
  output ptld_pkg::ptld_result_t result_o
);
  import ptld_pkg::*;

  logic [15:0] ticks_q, ticks_d;
  logic        last_near_q, last_near_d;
  logic [1:0]  count_q, count_d;
  logic        switch_q, switch_d;
  logic [7:0]  level_q, level_d;

  logic       sample;
  logic       near;
  logic       change;
  logic       win;
  logic [7:0] target;

  always_comb begin
    sample = ticks_q >= cfg_i.sample_interval;
    near   = range_cm_i < cfg_i.near_threshold;
    change = sample && (near != last_near_q);

    count_d     = change ? count_q + 2'd1 : count_q;
    last_near_d = change ? near : last_near_q;
    switch_d    = sample ? (count_d != 2'd0) : switch_q;

    if (sample) begin
      ticks_d = 16'd1;
    end else if (ticks_q != TickSat) begin
      ticks_d = ticks_q + 16'd1;
    end else begin
      ticks_d = ticks_q;
    end

    if (cfg_i.window_start_hour <= cfg_i.window_end_hour) begin
      win = (hour_now_i >= cfg_i.window_start_hour) && (hour_now_i < cfg_i.window_end_hour);
    end else begin
      win = (hour_now_i >= cfg_i.window_start_hour) || (hour_now_i < cfg_i.window_end_hour);
    end

    if (!switch_d) begin
      target = 8'd0;
    end else begin
      target = win ? cfg_i.level_in_window : cfg_i.level_outside;
    end

    priority if (level_q < target) begin
      level_d = level_q + RampUpStep;
    end else if (level_q > target) begin
      level_d = (level_q <= RampDownStep) ? 8'd0 : level_q - RampDownStep;
    end else begin
      level_d = level_q;
    end

    result_o.lamp_level      = level_d;
    result_o.indicator_level = LevelFull - level_d;
    result_o.switch_on       = switch_d;
    result_o.gesture_count   = count_d;
    result_o.in_window       = win;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      last_near_q <= 1'b0;
      count_q     <= '0;
      switch_q    <= 1'b0;
      level_q     <= '0;
    end else if (step_i) begin
      ticks_q     <= ticks_d;
      last_near_q <= last_near_d;
      count_q     <= count_d;
      switch_q    <= switch_d;
      level_q     <= level_d;
    end
  end

endmodule

// File: sv/proximity_toggle_lamp_dimmer_core.sv
// ----------------------------------------------------------------------------
// proximity_toggle_lamp_dimmer_core
// Proximity-toggled lamp dimmer with an hour-of-day brightness window.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tick request: the
//   current hour and the latest distance reading. Output channel
//   (out_valid_o/out_ready_i) returns one result per tick: lamp level,
//   its inverse for the indicator, switch state, gesture count and the
//   window flag.
//   Configuration is a plain write port (cfg_we_i, cfg_addr_i,
//   cfg_wdata_i); write only while no request is in flight.
//   Each accepted request passes through an input register, then the state
//   update into the result register. Throughput is one request per cycle
//   while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; ready drops only when both
//   are full.
//   Reset clears the valid flags, the tick state and configuration (the
//   data registers are not reset); sample interval resets to 1000 ticks.
// ----------------------------------------------------------------------------
module proximity_toggle_lamp_dimmer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptld_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ptld_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [4:0]                    hour_now_i,
  input  logic [9:0]                    range_cm_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    lamp_level_o,
  output logic [7:0]                    indicator_level_o,
  output logic                          switch_on_o,
  output logic [1:0]                    gesture_count_o,
  output logic                          in_window_o
);
  import ptld_pkg::*;

  ptld_cfg_t    cfg;
  ptld_result_t step_res;
  ptld_result_t res_q;

  logic       in_valid_q;
  logic [4:0] hour_q;
  logic [9:0] range_q;
  logic       out_valid_q;
  logic       step;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  ptld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptld_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .hour_now_i (hour_q),
    .range_cm_i (range_q),
    .cfg_i      (cfg),
    .result_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hour_q  <= hour_now_i;
      range_q <= range_cm_i;
    end
    if (step) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lamp_level_o      = res_q.lamp_level;
  assign indicator_level_o = res_q.indicator_level;
  assign switch_on_o       = res_q.switch_on;
  assign gesture_count_o   = res_q.gesture_count;
  assign in_window_o       = res_q.in_window;

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_indicator_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (indicator_level_o == ~lamp_level_o))
    else $error("indicator is not the inverse of lamp level");

  a_switch_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (switch_on_o == (gesture_count_o != 2'd0)))
    else $error("switch state disagrees with gesture count");

  a_step_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed request produced no result");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for proximity_toggle_lamp_dimmer_core.
//
// Tick requests go in through a bursty valid/ready driver. Each accepted
// request is run through a local model of the sampler, gesture counter,
// hour window and level ramp, and the predicted result is queued. A
// monitor with its own stall pattern checks every result against the
// oldest prediction. Registers are rewritten between phases, only once
// the block has drained.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptld_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseTicks = 165;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdySparse, RdyPeriodic} rdy_mode_e;

  typedef struct {
    logic [4:0] hour;
    logic [9:0] range_cm;
  } tick_req_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [4:0]          hour_now_i  = '0;
  logic [9:0]          range_cm_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          lamp_level_o;
  logic [7:0]          indicator_level_o;
  logic                switch_on_o;
  logic [1:0]          gesture_count_o;
  logic                in_window_o;

  proximity_toggle_lamp_dimmer_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .hour_now_i        (hour_now_i),
    .range_cm_i        (range_cm_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .lamp_level_o      (lamp_level_o),
    .indicator_level_o (indicator_level_o),
    .switch_on_o       (switch_on_o),
    .gesture_count_o   (gesture_count_o),
    .in_window_o       (in_window_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // lamp model state and shadow registers
  ptld_cfg_t   cfg_shadow;
  logic [15:0] smp_ticks = '0;
  logic        was_near  = 1'b0;
  logic [1:0]  gest_cnt  = '0;
  logic        switch_st = 1'b0;
  logic [7:0]  lamp_lvl  = '0;

  tick_req_t    tick_req_q[$];
  ptld_result_t lamp_expect_q[$];
  int unsigned  err_cnt = 0;

  function automatic ptld_result_t predict_lamp(logic [4:0] hr, logic [9:0] rng);
    ptld_result_t res;
    logic         is_near;
    logic         win;
    logic [7:0]   target;
    if (smp_ticks >= cfg_shadow.sample_interval) begin
      is_near = rng < cfg_shadow.near_threshold;
      if (is_near != was_near) begin
        gest_cnt = gest_cnt + 2'd1;
        was_near = is_near;
      end
      switch_st = gest_cnt != 2'd0;
      smp_ticks = 16'd1;
    end else if (smp_ticks != TickSat) begin
      smp_ticks = smp_ticks + 16'd1;
    end
    if (cfg_shadow.window_start_hour <= cfg_shadow.window_end_hour) begin
      win = hr >= cfg_shadow.window_start_hour && hr < cfg_shadow.window_end_hour;
    end else begin
      win = hr >= cfg_shadow.window_start_hour || hr < cfg_shadow.window_end_hour;
    end
    if (!switch_st) begin
      target = 8'd0;
    end else begin
      target = win ? cfg_shadow.level_in_window : cfg_shadow.level_outside;
    end
    if (lamp_lvl < target) begin
      lamp_lvl = lamp_lvl + RampUpStep;
    end else if (lamp_lvl > target) begin
      lamp_lvl = (lamp_lvl <= RampDownStep) ? 8'd0 : lamp_lvl - RampDownStep;
    end
    res.lamp_level      = lamp_lvl;
    res.indicator_level = LevelFull - lamp_lvl;
    res.switch_on       = switch_st;
    res.gesture_count   = gest_cnt;
    res.in_window       = win;
    return res;
  endfunction

  function automatic bit work_left();
    return tick_req_q.size() != 0 || in_valid_i || lamp_expect_q.size() != 0;
  endfunction

  // request driver: bursts with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drv
    tick_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lamp_expect_q.push_back(predict_lamp(hour_now_i, range_cm_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tick_req_q.size() != 0) begin
          nxt = tick_req_q.pop_front();
          hour_now_i <= nxt.hour;
          range_cm_i <= nxt.range_cm;
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(10, 1);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  rdy_mode_e   rdy_mode = RdyAlways;
  int unsigned rdy_len  = 0;

  always @(posedge clk_i) begin : mon
    ptld_result_t got;
    ptld_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.lamp_level      = lamp_level_o;
        got.indicator_level = indicator_level_o;
        got.switch_on       = switch_on_o;
        got.gesture_count   = gesture_count_o;
        got.in_window       = in_window_o;
        if (lamp_expect_q.size() == 0) begin
          if (err_cnt < 10) begin
            $display("unexpected result: lamp=%0d ind=%0d sw=%0b gest=%0d win=%0b",
                     got.lamp_level, got.indicator_level, got.switch_on,
                     got.gesture_count, got.in_window);
          end
          err_cnt++;
        end else begin
          want = lamp_expect_q.pop_front();
          if (got.lamp_level !== want.lamp_level ||
              got.indicator_level !== want.indicator_level ||
              got.switch_on !== want.switch_on ||
              got.gesture_count !== want.gesture_count ||
              got.in_window !== want.in_window) begin
            if (err_cnt < 10) begin
              $display("mismatch @%0t: exp lamp=%0d ind=%0d sw=%0b gest=%0d win=%0b",
                       $realtime, want.lamp_level, want.indicator_level,
                       want.switch_on, want.gesture_count, want.in_window);
              $display("               got lamp=%0d ind=%0d sw=%0b gest=%0d win=%0b",
                       got.lamp_level, got.indicator_level, got.switch_on,
                       got.gesture_count, got.in_window);
            end
            err_cnt++;
          end
        end
      end
      if (rdy_len == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(3, 0));
        rdy_len  = $urandom_range(160, 16);
      end
      rdy_len--;
      case (rdy_mode)
        RdyAlways:   out_ready_i <= 1'b1;
        RdyCoin:     out_ready_i <= 1'($urandom_range(1, 0));
        RdySparse:   out_ready_i <= ($urandom_range(3, 0) == 0);
        default:     out_ready_i <= (rdy_len % 8) < 5;
      endcase
    end
  end

  // watchdog: quiet cycles while work is outstanding
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !work_left()) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegNearThreshold:  cfg_shadow.near_threshold    = val[9:0];
      RegWindowStart:    cfg_shadow.window_start_hour = val[4:0];
      RegWindowEnd:      cfg_shadow.window_end_hour   = val[4:0];
      RegLevelInWindow:  cfg_shadow.level_in_window   = val[7:0];
      RegLevelOutside:   cfg_shadow.level_outside     = val[7:0];
      RegSampleInterval: cfg_shadow.sample_interval   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // junk sets the unused upper bits of the narrower registers
  task automatic program_cfg(logic [9:0] thr, logic [4:0] st, logic [4:0] en,
                             logic [7:0] lin, logic [7:0] lout, logic [15:0] iv,
                             bit junk);
    cfg_write(RegNearThreshold, {junk ? 6'($urandom) : 6'd0, thr});
    cfg_write(RegWindowStart, {junk ? 11'($urandom) : 11'd0, st});
    cfg_write(RegWindowEnd, {junk ? 11'($urandom) : 11'd0, en});
    cfg_write(RegLevelInWindow, {junk ? 8'($urandom) : 8'd0, lin});
    cfg_write(RegLevelOutside, {junk ? 8'($urandom) : 8'd0, lout});
    cfg_write(RegSampleInterval, iv);
    if (junk) begin
      cfg_write(RegSpareLo, 16'($urandom));
      cfg_write(RegSpareHi, 16'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_tick(logic [4:0] hr, logic [9:0] rng);
    tick_req_t r;
    r.hour     = hr;
    r.range_cm = rng;
    tick_req_q.push_back(r);
  endtask

  // hand gestures: alternating near and far runs, with some noise runs
  task automatic queue_ticks(int unsigned n);
    int unsigned lim;
    int unsigned run;
    int unsigned kind;
    bit          near_run;
    logic [4:0]  hr;
    lim      = cfg_shadow.near_threshold;
    near_run = 1'b1;
    hr       = 5'($urandom_range(23, 0));
    while (n > 0) begin
      kind = $urandom_range(7, 0);
      run  = $urandom_range(24, 1);
      if ($urandom_range(3, 0) == 0) begin
        hr = ($urandom_range(15, 0) == 0) ? 5'($urandom_range(31, 24))
                                          : 5'($urandom_range(23, 0));
      end
      for (int i = 0; i < run && n > 0; i++) begin
        if (kind == 0) begin
          push_tick(5'($urandom), 10'($urandom));
        end else if (near_run && lim != 0) begin
          push_tick(hr, 10'($urandom_range(lim - 1, 0)));
        end else begin
          push_tick(hr, 10'($urandom_range(1023, lim)));
        end
        n--;
      end
      near_run = !near_run;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (work_left());
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stim
    logic [9:0]  thr;
    logic [4:0]  st;
    logic [4:0]  en;
    logic [7:0]  lin;
    logic [7:0]  lout;
    logic [15:0] iv;
    int unsigned sel;
    cfg_shadow                 = '0;
    cfg_shadow.sample_interval = SampleIntervalReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    push_tick(5'd23, 10'd1023);
    push_tick(5'd0, 10'd0);
    push_tick(5'd31, 10'd512);
    wait_drained();

    // wrapping window, threshold at max, sample every tick
    program_cfg(10'd1023, 5'd22, 5'd6, 8'd12, 8'd255, 16'd0, 1'b0);
    push_tick(5'd0, 10'd0);
    push_tick(5'd5, 10'd1022);
    push_tick(5'd6, 10'd1023);
    push_tick(5'd21, 10'd1023);
    push_tick(5'd22, 10'd0);
    push_tick(5'd23, 10'd500);
    push_tick(5'd24, 10'd1023);
    push_tick(5'd31, 10'd1023);
    push_tick(5'd0, 10'd1022);
    push_tick(5'd12, 10'd0);
    push_tick(5'd12, 10'd1023);
    push_tick(5'd3, 10'd1023);
    wait_drained();

    // empty window, nothing ever near; spare indexes written
    program_cfg(10'd0, 5'd7, 5'd7, 8'd255, 8'd0, 16'd1, 1'b1);
    push_tick(5'd7, 10'd0);
    push_tick(5'd8, 10'd1023);
    push_tick(5'd6, 10'd0);
    wait_drained();

    // plain window, threshold of one
    program_cfg(10'd1, 5'd3, 5'd9, 8'd20, 8'd5, 16'd2, 1'b0);
    push_tick(5'd2, 10'd0);
    push_tick(5'd3, 10'd0);
    push_tick(5'd8, 10'd1);
    push_tick(5'd9, 10'd0);
    push_tick(5'd3, 10'd0);
    push_tick(5'd2, 10'd1);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      sel = $urandom_range(7, 0);
      thr = (sel == 0) ? 10'd0 : (sel == 1) ? 10'd1023 : 10'($urandom_range(1023, 1));
      st  = ($urandom_range(7, 0) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23, 0));
      en  = ($urandom_range(7, 0) == 0) ? st : 5'($urandom_range(23, 0));
      case ($urandom_range(2, 0))
        0: begin
          lin  = 8'($urandom_range(20, 0));
          lout = 8'($urandom_range(20, 0));
        end
        1: begin
          lin  = 8'($urandom);
          lout = 8'($urandom);
        end
        default: begin
          lin  = $urandom_range(1, 0) ? 8'd255 : 8'd0;
          lout = $urandom_range(1, 0) ? 8'd255 : 8'd0;
        end
      endcase
      case ($urandom_range(5, 0))
        0, 4: iv = 16'd0;
        1:    iv = 16'd1;
        2:    iv = 16'($urandom_range(4, 2));
        3:    iv = 16'($urandom_range(30, 5));
        default: iv = 16'($urandom_range(200, 31));
      endcase
      if (p == 0) begin
        thr = 10'd1023;
        st  = 5'd0;
        en  = 5'd23;
        lin = 8'd255;
        lout = 8'd0;
        iv  = 16'd0;
      end else if (p == 1) begin
        iv = 16'hFFFF;
      end else if (p == 2) begin
        thr  = 10'd0;
        lin  = 8'd255;
        lout = 8'd255;
      end
      program_cfg(thr, st, en, lin, lout, iv, $urandom_range(3, 0) == 0);
      queue_ticks((p == 1) ? 40 : PhaseTicks);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
